>>> design/lkvc_pkg.sv
// Package for the LRU key-value cache: controller states, the command and
// status groups between controller and datapath, and fixed codes.
// No dependencies.
`default_nettype none

package lkvc_pkg;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [31:0] PUT_VALUE  = 32'h0000_0000;

	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_RESULT
	} lkvc_state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic apply;
		logic out_load;
	} lkvc_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} lkvc_sts_t;

endpackage

`default_nettype wire

>>> design/lkvc_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none

module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> design/lkvc_ctrl.sv
// Controller state machine of the LRU key-value cache.
// Depends on lkvc_pkg for the state type and the command and status groups.
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire lkvc_sts_t sts,
	output lkvc_cmd_t      cmd
);

	lkvc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/lkvc_dp.sv
// Datapath of the LRU key-value cache: key scan, recency ranks, valid bits,
// capacity register, key and value memories, and the result register.
// Depends on lkvc_pkg and lkvc_ram.
`default_nettype none

module lkvc_dp import lkvc_pkg::*; #(
	parameter int ENTRIES = 16,
	localparam int IW = $clog2(ENTRIES),
	localparam int OW = $clog2(ENTRIES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic        [4:0]  capacity,
	input  wire logic               mode,
	input  wire logic signed [31:0] lookup_key,
	input  wire logic signed [31:0] write_value,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic                    hit,
	output logic signed      [31:0] read_value,
	input  wire lkvc_cmd_t          cmd,
	output lkvc_sts_t               sts
);

	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]      age_q [ENTRIES];
	logic [OW-1:0]      occ_q;
	logic [OW-1:0]      cnt_q;
	logic [4:0]         capacity_q;

	logic               mode_q;
	logic [31:0]        key_q;
	logic [31:0]        wval_q;
	logic               hit_q;
	logic               slot_found_q;
	logic [IW-1:0]      hit_idx_q;
	logic [IW-1:0]      slot_idx_q;

	logic               out_valid_q;
	logic               out_hit_q;
	logic [31:0]        out_value_q;

	logic [OW-1:0]      cap_eff;
	logic [OW-1:0]      cap_m1;
	logic               evict_on;
	logic               cmp_en;
	logic [IW-1:0]      cmp_idx;
	logic               cmp_valid;
	logic [IW-1:0]      cmp_age;
	logic               cmp_match;
	logic               cmp_free;
	logic [ENTRIES-1:0] evict_mask;
	logic [IW-1:0]      hit_age;
	logic               put_miss;

	logic [31:0]        key_rdata;
	logic [31:0]        val_rdata;
	logic               key_we;
	logic               val_we;
	logic [IW-1:0]      val_waddr;

	always_comb begin
		if (capacity_q == 5'd0) begin
			cap_eff = OW'(1);
		end else if (32'(capacity_q) > 32'(ENTRIES)) begin
			cap_eff = OW'(ENTRIES);
		end else begin
			cap_eff = OW'(capacity_q);
		end
	end

	assign cap_m1    = cap_eff - OW'(1);
	assign evict_on  = occ_q >= cap_eff;
	assign cmp_en    = cmd.scan && (cnt_q != '0);
	assign cmp_idx   = IW'(cnt_q - OW'(1));
	assign cmp_valid = valid_q[cmp_idx];
	assign cmp_age   = age_q[cmp_idx];
	assign cmp_match = cmp_valid && (key_rdata == key_q);
	assign cmp_free  = !cmp_valid || (evict_on && (OW'(cmp_age) >= cap_m1));
	assign hit_age   = age_q[hit_idx_q];
	assign put_miss  = (mode_q == MODE_PUT) && !hit_q;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			evict_mask[i] = evict_on && valid_q[i] && (OW'(age_q[i]) >= cap_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RESET;
			valid_q      <= '0;
			occ_q        <= '0;
			cnt_q        <= '0;
			hit_q        <= 1'b0;
			slot_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_hit_q    <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				capacity_q <= capacity;
			end
			if (cmd.accept) begin
				cnt_q        <= '0;
				hit_q        <= 1'b0;
				slot_found_q <= 1'b0;
			end
			if (cmd.scan) begin
				cnt_q <= cnt_q + OW'(1);
				if (cmp_en && cmp_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cmp_en && cmp_free && !slot_found_q) begin
					slot_found_q <= 1'b1;
				end
			end
			if (cmd.apply) begin
				if (hit_q) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && (age_q[i] < hit_age)) begin
							age_q[i] <= age_q[i] + IW'(1);
						end
					end
					age_q[hit_idx_q] <= '0;
				end else if (mode_q == MODE_PUT) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (evict_mask[i]) begin
							valid_q[i] <= 1'b0;
							age_q[i]   <= '0;
						end else if (valid_q[i]) begin
							age_q[i] <= age_q[i] + IW'(1);
						end
					end
					valid_q[slot_idx_q] <= 1'b1;
					age_q[slot_idx_q]   <= '0;
					occ_q <= (evict_on ? cap_m1 : occ_q) + OW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
		if (cmp_en && cmp_match && !hit_q) begin
			hit_idx_q <= cmp_idx;
		end
		if (cmp_en && cmp_free && !slot_found_q) begin
			slot_idx_q <= cmp_idx;
		end
		if (cmd.out_load) begin
			if (mode_q == MODE_PUT) begin
				out_value_q <= PUT_VALUE;
			end else if (hit_q) begin
				out_value_q <= val_rdata;
			end else begin
				out_value_q <= MISS_VALUE;
			end
		end
	end

	assign key_we    = cmd.apply && put_miss;
	assign val_we    = cmd.apply && (mode_q == MODE_PUT);
	assign val_waddr = hit_q ? hit_idx_q : slot_idx_q;

	lkvc_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_idx_q),
		.wdata (key_q),
		.raddr (cnt_q[IW-1:0]),
		.rdata (key_rdata)
	);

	lkvc_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (wval_q),
		.raddr (hit_idx_q),
		.rdata (val_rdata)
	);

	assign sts.scan_last = (cnt_q == OW'(ENTRIES));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign read_value = out_value_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("Occupancy differs from the number of valid entries.");

	a_occ_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("Occupancy exceeds the number of entries.");

	a_insert_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && put_miss |-> slot_found_q)
		else $error("Insert without a free or evictable slot.");

	a_insert_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && put_miss |=> occ_q != '0)
		else $error("Insert left the cache empty.");

endmodule

`default_nettype wire

>>> design/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_dp and lkvc_ram.
//
//   Channel  Handshake               Payload
//   cfg      cfg_valid / cfg_ready   capacity
//   in       in_valid / in_stall     mode, lookup_key, write_value
//   out      out_valid / out_stall   hit, read_value
//
// Each transaction is accepted, then scans the key memory one entry per cycle
// through its registered read port, then updates ranks and memories, and
// finally loads the result register.
// Reset clears all valid marks, ranks and occupancy at once; capacity resets to 16.
// A new transaction is accepted while the previous result waits in the result
// register; a stalled output holds the controller only at its final step.
`default_nettype none

module lru_key_value_cache import lkvc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [4:0]  capacity,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic signed [31:0] lookup_key,
	input  wire logic signed [31:0] write_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit,
	output logic signed      [31:0] read_value
);

	lkvc_cmd_t cmd;
	lkvc_sts_t sts;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkvc_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.capacity    (capacity),
		.mode        (mode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.hit         (hit),
		.read_value  (read_value),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire
